// ===== sv/utf8d_pkg.sv =====
// Shared types and constants for the UTF-8 to BMP code point decoder.
package utf8d_pkg;

    localparam int BYTE_W  = 8;
    localparam int CP_W    = 16;
    localparam int COUNT_W = 12;
    localparam int REM_W   = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_CONT  = 2'd1,
        PH_ABORT = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_CHAR = 2'd0,
        ST_END  = 2'd1,
        ST_ERR  = 2'd2
    } status_t;

    typedef struct packed {
        status_t              status;
        logic [CP_W-1:0]      code_point;
        logic [COUNT_W-1:0]   char_count;
    } result_t;

    // Handshake between the decode stage and the result register.
    typedef struct packed {
        logic emit;
        logic free;
    } out_ctrl_t;

endpackage

// ===== sv/utf8d_in_stage.sv =====
// Input register that holds one byte request until the decode stage consumes it.
module utf8d_in_stage (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [utf8d_pkg::BYTE_W-1:0]  byte_value,
    input  logic                          consume,
    output logic                          held_valid,
    output logic [utf8d_pkg::BYTE_W-1:0]  held_byte
);

    logic                          valid_reg;
    logic                          valid_next;
    logic [utf8d_pkg::BYTE_W-1:0]  byte_reg;

    // The register can take a new request when empty or when it empties this cycle.
    assign in_ready = !valid_reg || consume;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= byte_value;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

endmodule

// ===== sv/utf8d_decode.sv =====
// Decode state and the one-step byte decode logic.
module utf8d_decode (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          held_valid,
    input  logic [utf8d_pkg::BYTE_W-1:0]  held_byte,
    input  logic                          out_free,
    output logic                          consume,
    output utf8d_pkg::out_ctrl_t          ctrl,
    output utf8d_pkg::result_t            result
);

    utf8d_pkg::phase_t                     phase_reg;
    utf8d_pkg::phase_t                     phase_next;
    logic [utf8d_pkg::CP_W-1:0]            partial_reg;
    logic [utf8d_pkg::CP_W-1:0]            partial_next;
    logic [utf8d_pkg::REM_W-1:0]           rem_reg;
    logic [utf8d_pkg::REM_W-1:0]           rem_next;
    logic [utf8d_pkg::COUNT_W-1:0]         count_reg;
    logic [utf8d_pkg::COUNT_W-1:0]         count_next;
    logic [utf8d_pkg::COUNT_W-1:0]         count_bump;
    logic [utf8d_pkg::CP_W-1:0]            shifted;
    logic                                  emit;
    logic                                  fail;
    logic                                  byte_zero;

    assign byte_zero  = (held_byte == '0);
    assign count_bump = (count_reg == utf8d_pkg::COUNT_MAX) ? count_reg
                                                            : count_reg + 1'b1;
    assign shifted    = {partial_reg[utf8d_pkg::CP_W-7:0], held_byte[5:0]};

    always_comb
    begin
        phase_next        = phase_reg;
        partial_next      = partial_reg;
        rem_next          = rem_reg;
        count_next        = count_reg;
        emit              = 1'b0;
        fail              = 1'b0;
        result.status     = utf8d_pkg::ST_CHAR;
        result.code_point = '0;
        result.char_count = count_reg;

        case (phase_reg)
            utf8d_pkg::PH_ABORT:
            begin
                if (byte_zero)
                begin
                    phase_next = utf8d_pkg::PH_IDLE;
                    count_next = '0;
                end
            end
            utf8d_pkg::PH_CONT:
            begin
                if (held_byte[7:6] != 2'b10)
                begin
                    fail = 1'b1;
                end
                else if (rem_reg <= 2'd1)
                begin
                    emit              = 1'b1;
                    result.code_point = shifted;
                    result.char_count = count_bump;
                    count_next        = count_bump;
                    partial_next      = '0;
                    rem_next          = '0;
                    phase_next        = utf8d_pkg::PH_IDLE;
                end
                else
                begin
                    partial_next = shifted;
                    rem_next     = rem_reg - 1'b1;
                end
            end
            default:
            begin
                // The unused phase code behaves as idle.
                phase_next = utf8d_pkg::PH_IDLE;
                if (byte_zero)
                begin
                    emit          = 1'b1;
                    result.status = utf8d_pkg::ST_END;
                    count_next    = '0;
                end
                else if (!held_byte[7])
                begin
                    emit              = 1'b1;
                    result.code_point = {{(utf8d_pkg::CP_W-utf8d_pkg::BYTE_W){1'b0}},
                                         held_byte};
                    result.char_count = count_bump;
                    count_next        = count_bump;
                end
                else if (held_byte[7:5] == 3'b110)
                begin
                    partial_next = {{(utf8d_pkg::CP_W-5){1'b0}}, held_byte[4:0]};
                    rem_next     = 2'd1;
                    phase_next   = utf8d_pkg::PH_CONT;
                end
                else if (held_byte[7:4] == 4'b1110)
                begin
                    partial_next = {{(utf8d_pkg::CP_W-4){1'b0}}, held_byte[3:0]};
                    rem_next     = 2'd2;
                    phase_next   = utf8d_pkg::PH_CONT;
                end
                else
                begin
                    fail = 1'b1;
                end
            end
        endcase

        if (fail)
        begin
            emit              = 1'b1;
            result.status     = utf8d_pkg::ST_ERR;
            result.code_point = '0;
            result.char_count = count_reg;
            partial_next      = '0;
            rem_next          = '0;
            if (byte_zero)
            begin
                phase_next = utf8d_pkg::PH_IDLE;
                count_next = '0;
            end
            else
            begin
                phase_next = utf8d_pkg::PH_ABORT;
            end
        end
    end

    // A byte that yields no result never waits on the output side.
    assign consume   = held_valid && (!emit || out_free);
    assign ctrl.emit = consume && emit;
    assign ctrl.free = out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= utf8d_pkg::PH_IDLE;
            partial_reg <= '0;
            rem_reg     <= '0;
            count_reg   <= '0;
        end
        else if (consume)
        begin
            phase_reg   <= phase_next;
            partial_reg <= partial_next;
            rem_reg     <= rem_next;
            count_reg   <= count_next;
        end
    end

endmodule

// ===== sv/utf8d_out_stage.sv =====
// Result register that holds one result request until the consumer takes it.
module utf8d_out_stage (
    input  logic                  clk,
    input  logic                  rst_n,
    input  utf8d_pkg::out_ctrl_t  ctrl,
    input  utf8d_pkg::result_t    result,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic                  out_free,
    output utf8d_pkg::result_t    held_result
);

    logic                valid_reg;
    logic                valid_next;
    utf8d_pkg::result_t  result_reg;

    assign out_free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (ctrl.free)
        begin
            valid_next = ctrl.emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.emit)
        begin
            result_reg <= result;
        end
    end

    assign out_valid   = valid_reg;
    assign held_result = result_reg;

endmodule

// ===== sv/utf8_to_bmp_code_point_decoder.sv =====
// Top level of the UTF-8 to BMP code point decoder.
//
//   channel   handshake             payload
//   input     in_valid / in_ready   byte_value
//   output    out_valid / out_ready status, code_point, char_count
//
// One byte request per cycle is sustained while no result waits on a stalled
// output. A byte is registered in the input stage, decoded against the decode
// state, and its result, if any, is then registered in the result register.
// Reset returns the decoder to idle with a zero count and empties both stages.
// A stalled output holds the result register; bytes that yield no result still
// move on, and input ready drops only when a result must wait.
module utf8_to_bmp_code_point_decoder (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [utf8d_pkg::BYTE_W-1:0]    byte_value,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [1:0]                      status,
    output logic [utf8d_pkg::CP_W-1:0]      code_point,
    output logic [utf8d_pkg::COUNT_W-1:0]   char_count
);

    logic                          held_valid;
    logic [utf8d_pkg::BYTE_W-1:0]  held_byte;
    logic                          consume;
    logic                          out_free;
    utf8d_pkg::out_ctrl_t          ctrl;
    utf8d_pkg::result_t            result;
    utf8d_pkg::result_t            held_result;

    utf8d_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .byte_value (byte_value),
        .consume    (consume),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    utf8d_decode u_dec (
        .clk        (clk),
        .rst_n      (rst_n),
        .held_valid (held_valid),
        .held_byte  (held_byte),
        .out_free   (out_free),
        .consume    (consume),
        .ctrl       (ctrl),
        .result     (result)
    );

    utf8d_out_stage u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .result      (result),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .out_free    (out_free),
        .held_result (held_result)
    );

    assign status     = held_result.status;
    assign code_point = held_result.code_point;
    assign char_count = held_result.char_count;

endmodule

// ===== sv/utf8d_checker.sv =====
// Port-level checks for the UTF-8 decoder and their binding to the top level.
module utf8d_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  logic [1:0]                      status,
    input  logic [utf8d_pkg::CP_W-1:0]      code_point,
    input  logic [utf8d_pkg::COUNT_W-1:0]   char_count
);

    // A stalled result request keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(code_point) && $stable(char_count))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == utf8d_pkg::ST_CHAR || status == utf8d_pkg::ST_END
            || status == utf8d_pkg::ST_ERR)
        else $error("unknown status code");

    a_cp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != utf8d_pkg::ST_CHAR |-> code_point == '0)
        else $error("code point not zero on end or error");

    // A decoded character is always counted.
    a_char_counted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == utf8d_pkg::ST_CHAR |-> char_count != '0)
        else $error("decoded character with zero count");

endmodule

bind utf8_to_bmp_code_point_decoder utf8d_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .code_point (code_point),
    .char_count (char_count)
);

// ===== tb/tb_utf8_to_bmp_code_point_decoder.sv =====
// Self-checking testbench for the UTF-8 to BMP code point decoder.
`timescale 1ns / 100ps

module tb_utf8_to_bmp_code_point_decoder;

    localparam int RANDOM_BYTES = 1600;
    localparam int DRAIN_CYCLES = 20;

    typedef logic [utf8d_pkg::BYTE_W-1:0] byte_t;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    logic [utf8d_pkg::BYTE_W-1:0]   byte_value;
    logic                           out_valid;
    logic                           out_ready;
    logic [1:0]                     status;
    logic [utf8d_pkg::CP_W-1:0]     code_point;
    logic [utf8d_pkg::COUNT_W-1:0]  char_count;

    bit burst_in;
    bit burst_out;

    utf8_to_bmp_code_point_decoder DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .byte_value (byte_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .code_point (code_point),
        .char_count (char_count)
    );

    class utf8_scoreboard;
        utf8d_pkg::phase_t              phase;
        logic [utf8d_pkg::CP_W-1:0]     partial;
        logic [utf8d_pkg::REM_W-1:0]    remaining;
        logic [utf8d_pkg::COUNT_W-1:0]  count;
        utf8d_pkg::result_t             decoded_q[$];
        int                             mismatches;
        int                             bytes_seen;
        int                             bytes_dropped;
        int                             results_seen;
        int                             n_char;
        int                             n_end;
        int                             n_err;
        int                             max_count;

        function new();
            phase     = utf8d_pkg::PH_IDLE;
            partial   = '0;
            remaining = '0;
            count     = '0;
        endfunction

        function int pending();
            return decoded_q.size();
        endfunction

        function void bump_count();
            if (count != utf8d_pkg::COUNT_MAX)
                count++;
        endfunction

        // A bad byte ends the character; a zero byte also ends the string.
        function utf8d_pkg::result_t abort_char(byte_t b);
            utf8d_pkg::result_t r;
            r.status     = utf8d_pkg::ST_ERR;
            r.code_point = '0;
            r.char_count = count;
            partial      = '0;
            remaining    = '0;
            if (b == '0)
            begin
                phase = utf8d_pkg::PH_IDLE;
                count = '0;
            end
            else
                phase = utf8d_pkg::PH_ABORT;
            return r;
        endfunction

        function void note_byte(byte_t b);
            utf8d_pkg::result_t r;
            bit                 emit;
            emit = 0;
            r    = '0;
            bytes_seen++;
            case (phase)
                utf8d_pkg::PH_ABORT:
                begin
                    bytes_dropped++;
                    if (b == '0)
                    begin
                        phase = utf8d_pkg::PH_IDLE;
                        count = '0;
                    end
                end
                utf8d_pkg::PH_CONT:
                begin
                    emit = 1;
                    if (b[7:6] != 2'b10)
                        r = abort_char(b);
                    else
                    begin
                        partial = {partial[utf8d_pkg::CP_W-7:0], b[5:0]};
                        if (remaining <= 1)
                        begin
                            bump_count();
                            r.status     = utf8d_pkg::ST_CHAR;
                            r.code_point = partial;
                            r.char_count = count;
                            partial      = '0;
                            remaining    = '0;
                            phase        = utf8d_pkg::PH_IDLE;
                        end
                        else
                        begin
                            remaining--;
                            emit = 0;
                        end
                    end
                end
                default:
                begin
                    phase = utf8d_pkg::PH_IDLE;
                    emit  = 1;
                    if (b == '0)
                    begin
                        r.status     = utf8d_pkg::ST_END;
                        r.code_point = '0;
                        r.char_count = count;
                        count        = '0;
                    end
                    else if (b[7] == 1'b0)
                    begin
                        bump_count();
                        r.status     = utf8d_pkg::ST_CHAR;
                        r.code_point = {8'h00, b};
                        r.char_count = count;
                    end
                    else if (b[7:5] == 3'b110)
                    begin
                        partial   = {11'd0, b[4:0]};
                        remaining = 2'd1;
                        phase     = utf8d_pkg::PH_CONT;
                        emit      = 0;
                    end
                    else if (b[7:4] == 4'b1110)
                    begin
                        partial   = {12'd0, b[3:0]};
                        remaining = 2'd2;
                        phase     = utf8d_pkg::PH_CONT;
                        emit      = 0;
                    end
                    else
                        r = abort_char(b);
                end
            endcase
            if (emit)
                decoded_q.push_back(r);
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(logic [1:0] st, logic [utf8d_pkg::CP_W-1:0] cp,
                          logic [utf8d_pkg::COUNT_W-1:0] cnt);
            utf8d_pkg::result_t exp_r;
            results_seen++;
            if (decoded_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result status=%0d cp=%h count=%0d",
                                          st, cp, cnt));
                return;
            end
            exp_r = decoded_q.pop_front();
            if (st !== exp_r.status)
                report_mismatch($sformatf("status %0d, predicted %0d", st, exp_r.status));
            if (cp !== exp_r.code_point)
                report_mismatch($sformatf("code_point %h, predicted %h", cp, exp_r.code_point));
            if (cnt !== exp_r.char_count)
                report_mismatch($sformatf("char_count %0d, predicted %0d",
                                          cnt, exp_r.char_count));
            case (exp_r.status)
                utf8d_pkg::ST_CHAR: n_char++;
                utf8d_pkg::ST_END:  n_end++;
                default:            n_err++;
            endcase
            if (int'(exp_r.char_count) > max_count)
                max_count = int'(exp_r.char_count);
        endtask
    endclass

    utf8_scoreboard sb;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int draw_gap(inout bit burst);
        if ($urandom_range(0, 63) == 0)
            burst = !burst;
        return burst ? 0 : $urandom_range(0, 15);
    endfunction

    function automatic byte_t cont_byte();
        return byte_t'($urandom_range('h80, 'hBF));
    endfunction

    // Called and returns at a falling edge; valid stays high across back-to-back requests.
    task automatic send_byte(input byte_t b);
        int gap;
        gap = draw_gap(burst_in);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   = 1'b1;
        byte_value = b;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_byte(b);
        @(negedge clk);
    endtask

    task automatic send_random_char();
        case ($urandom_range(0, 3))
            0, 1:
                send_byte(byte_t'($urandom_range(1, 127)));
            2:
            begin
                send_byte(byte_t'($urandom_range('hC0, 'hDF)));
                send_byte(cont_byte());
            end
            default:
            begin
                send_byte(byte_t'($urandom_range('hE0, 'hEF)));
                send_byte(cont_byte());
                send_byte(cont_byte());
            end
        endcase
    endtask

    // Tries to break the current string in one of several ways and then terminates it.
    task automatic send_fault();
        byte_t b;
        int    n_noise;
        case ($urandom_range(0, 4))
            0:
                send_byte(byte_t'($urandom_range('hF0, 'hFF)));
            1:
                send_byte(cont_byte());
            2:
            begin
                send_byte(byte_t'($urandom_range('hC0, 'hEF)));
                do
                    b = byte_t'($urandom_range(1, 255));
                while (b[7:6] == 2'b10);
                send_byte(b);
            end
            3:
            begin
                // A zero byte inside a character ends the string by itself.
                send_byte(byte_t'($urandom_range('hC0, 'hEF)));
                if ($urandom_range(0, 1) == 1)
                    send_byte(cont_byte());
                send_byte('0);
                return;
            end
            default:
                send_byte(byte_t'($urandom_range(1, 255)));
        endcase
        n_noise = $urandom_range(0, 4);
        repeat (n_noise) send_byte(byte_t'($urandom_range(1, 255)));
        send_byte('0);
    endtask

    task automatic wait_for_drain();
        if (sb.pending() > 0)
        begin
            in_valid = 1'b0;
            while (sb.pending() > 0)
                @(negedge clk);
        end
    endtask

    task automatic receive_results();
        int stall;
        forever
        begin
            stall = draw_gap(burst_out);
            if (stall > 0)
            begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            sb.check_result(status, code_point, char_count);
            @(negedge clk);
        end
    endtask

    initial
    begin
        #8_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        int base;
        int n_chars;
        sb         = new();
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        byte_value = '0;
        out_ready  = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        fork
            receive_results();
        join_none

        // Empty string, boundary characters of every length, then the error paths.
        send_byte(8'h00);
        send_byte(8'h41);
        send_byte(8'h7F);
        send_byte(8'h01);
        send_byte(8'hC2);
        send_byte(8'hA9);
        send_byte(8'hDF);
        send_byte(8'hBF);
        send_byte(8'hE2);
        send_byte(8'h82);
        send_byte(8'hAC);
        send_byte(8'hEF);
        send_byte(8'hBF);
        send_byte(8'hBF);
        send_byte(8'h00);
        send_byte(8'h80);
        send_byte(8'h41);
        send_byte(8'h00);
        send_byte(8'hF0);
        send_byte(8'h00);
        send_byte(8'hC3);
        send_byte(8'h41);
        send_byte(8'h00);
        send_byte(8'hE2);
        send_byte(8'h00);
        wait_for_drain();

        base = sb.bytes_seen - sb.bytes_dropped;
        while (sb.bytes_seen - sb.bytes_dropped - base < RANDOM_BYTES)
        begin
            n_chars = $urandom_range(0, 12);
            repeat (n_chars) send_random_char();
            if ($urandom_range(0, 5) == 0)
                send_fault();
            else
                send_byte(8'h00);
            if ($urandom_range(0, 29) == 0)
                wait_for_drain();
        end

        in_valid = 1'b0;
        while (sb.pending() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Run: %0d byte requests (%0d dropped after an abort), %0d results checked.",
                 sb.bytes_seen, sb.bytes_dropped, sb.results_seen);
        $display("Run: %0d code points, %0d string ends, %0d errors, highest count %0d.",
                 sb.n_char, sb.n_end, sb.n_err, sb.max_count);
        if (sb.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
